FILE: rtl/rgcd_pkg.sv
package rgcd_pkg;

  // result widths are fixed by the field list
  localparam int unsigned NUM_BITS      = 33;
  localparam int unsigned DEN_BITS      = 32;
  // a product of two operands of up to 32 bits, before wrapping
  localparam int unsigned PROD_EXT_BITS = 64;
  // shift count of the divider, must hold NUM_BITS - 1
  localparam int unsigned CNT_BITS      = $clog2(NUM_BITS);

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_CHECK,
    ST_GCD_ISSUE,
    ST_GCD_WAIT,
    ST_DIVN_ISSUE,
    ST_DIVN_WAIT,
    ST_DIVD_ISSUE,
    ST_DIVD_WAIT,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_ALIGN,
    DIV_SUB
  } div_state_e;

  // handshake between the sequencer and the divider
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic done;
  } div_rsp_t;

endpackage

FILE: rtl/rational_arith_with_gcd_reduce_unit.sv
// sequence: multiply states ST_MUL0 to ST_MUL3, a check state, Euclid steps that each run
// one division on the divider, two exact divisions of numerator and denominator by the gcd
// and a done state; a zero denominator goes from the check state straight to done
// throughput: one transaction at a time, busy stays high until done_o
// the result is strobed on done_o for one cycle; the receiver cannot stall
// reset (rst_ni low, asynchronous) returns the sequencer and divider to idle
module rational_arith_with_gcd_reduce_unit
  import rgcd_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       command_i,
  input  logic signed [OPERAND_WIDTH-1:0]  first_numerator_i,
  input  logic signed [OPERAND_WIDTH-1:0]  first_denominator_i,
  input  logic signed [OPERAND_WIDTH-1:0]  second_numerator_i,
  input  logic signed [OPERAND_WIDTH-1:0]  second_denominator_i,
  output logic                             done_o,
  output logic signed [NUM_BITS-1:0]       raw_numerator_o,
  output logic signed [DEN_BITS-1:0]       raw_denominator_o,
  output logic signed [NUM_BITS-1:0]       reduced_numerator_o,
  output logic signed [DEN_BITS-1:0]       reduced_denominator_o,
  output logic                             zero_denominator_error_o
);

  localparam int unsigned W = OPERAND_WIDTH;

  state_e                      state_q, state_d;
  cmd_e                        op_q;
  logic signed [W-1:0]         a_q, b_q, c_q, d_q;
  logic signed [W-1:0]         mul_a, mul_b;
  logic signed [2*W-1:0]       mul_p;
  logic signed [PROD_EXT_BITS-1:0] mul_ext;
  logic signed [NUM_BITS-1:0]  prod_q;
  logic signed [NUM_BITS-1:0]  num_q;
  logic signed [DEN_BITS-1:0]  den_q;
  logic signed [NUM_BITS-1:0]  rnum_q;
  logic signed [DEN_BITS-1:0]  rden_q;
  logic                        err_q;
  logic [NUM_BITS-1:0]         x_q, y_q;
  logic [NUM_BITS-1:0]         mag_num, mag_den;
  logic signed [NUM_BITS-1:0]  den_ext;
  logic [NUM_BITS-1:0]         div_dividend, div_divisor;
  logic [NUM_BITS-1:0]         div_quo, div_rem;
  div_req_t                    div_req;
  div_rsp_t                    div_rsp;
  logic                        add_sub;

  assign add_sub = (op_q == CMD_ADD) || (op_q == CMD_SUB);

  assign den_ext = NUM_BITS'(den_q);
  assign mag_num = num_q[NUM_BITS-1] ? NUM_BITS'(-num_q) : NUM_BITS'(num_q);
  assign mag_den = den_ext[NUM_BITS-1] ? NUM_BITS'(-den_ext) : NUM_BITS'(den_ext);

  // shared multiplier, products wrap to the numerator width
  assign mul_p   = mul_a * mul_b;
  assign mul_ext = PROD_EXT_BITS'(mul_p);

  rgcd_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .rsp_o       (div_rsp),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:       if (start) state_d = ST_MUL0;
      ST_MUL0:       state_d = ST_MUL1;
      ST_MUL1:       state_d = ST_MUL2;
      ST_MUL2:       state_d = ST_MUL3;
      ST_MUL3:       state_d = ST_CHECK;
      ST_CHECK:      state_d = (den_q == '0) ? ST_DONE : ST_GCD_ISSUE;
      ST_GCD_ISSUE:  state_d = (y_q == '0) ? ST_DIVN_ISSUE : ST_GCD_WAIT;
      ST_GCD_WAIT:   if (div_rsp.done) state_d = ST_GCD_ISSUE;
      ST_DIVN_ISSUE: state_d = ST_DIVN_WAIT;
      ST_DIVN_WAIT:  if (div_rsp.done) state_d = ST_DIVD_ISSUE;
      ST_DIVD_ISSUE: state_d = ST_DIVD_WAIT;
      ST_DIVD_WAIT:  if (div_rsp.done) state_d = ST_DONE;
      ST_DONE:       state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // control outputs and operand selection
  always_comb begin
    busy          = (state_q != ST_IDLE);
    done_o        = (state_q == ST_DONE);
    div_req.start = 1'b0;
    div_dividend  = x_q;
    div_divisor   = y_q;
    mul_a         = a_q;
    mul_b         = d_q;
    unique case (state_q)
      ST_MUL0: begin
        mul_a = a_q;
        mul_b = (op_q == CMD_MUL) ? c_q : d_q;
      end
      ST_MUL1: begin
        mul_a = (op_q == CMD_MUL) ? b_q : c_q;
        mul_b = (op_q == CMD_MUL) ? d_q : b_q;
      end
      ST_MUL2: begin
        mul_a = b_q;
        mul_b = d_q;
      end
      ST_GCD_ISSUE: begin
        div_req.start = (y_q != '0);
      end
      ST_DIVN_ISSUE, ST_DIVN_WAIT: begin
        div_req.start = (state_q == ST_DIVN_ISSUE);
        div_dividend  = mag_num;
        div_divisor   = x_q;
      end
      ST_DIVD_ISSUE, ST_DIVD_WAIT: begin
        div_req.start = (state_q == ST_DIVD_ISSUE);
        div_dividend  = mag_den;
        div_divisor   = x_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_ext[NUM_BITS-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_q <= cmd_e'(command_i);
          a_q  <= first_numerator_i;
          b_q  <= first_denominator_i;
          c_q  <= second_numerator_i;
          d_q  <= second_denominator_i;
        end
      end
      ST_MUL1: num_q <= prod_q;
      ST_MUL2: begin
        if (op_q == CMD_ADD) begin
          num_q <= num_q + prod_q;
        end else if (op_q == CMD_SUB) begin
          num_q <= num_q - prod_q;
        end else begin
          den_q <= prod_q[DEN_BITS-1:0];
        end
      end
      ST_MUL3: if (add_sub) den_q <= prod_q[DEN_BITS-1:0];
      ST_CHECK: begin
        err_q <= (den_q == '0);
        x_q   <= mag_num;
        y_q   <= mag_den;
        if (den_q == '0) begin
          rnum_q <= '0;
          rden_q <= '0;
        end
      end
      ST_GCD_WAIT: begin
        if (div_rsp.done) begin
          x_q <= y_q;
          y_q <= div_rem;
        end
      end
      ST_DIVN_WAIT: begin
        if (div_rsp.done) begin
          rnum_q <= num_q[NUM_BITS-1] ? -$signed(div_quo) : $signed(div_quo);
        end
      end
      ST_DIVD_WAIT: begin
        if (div_rsp.done) begin
          rden_q <= den_q[DEN_BITS-1] ? -$signed(div_quo[DEN_BITS-1:0])
                                      : $signed(div_quo[DEN_BITS-1:0]);
        end
      end
      default: ;
    endcase
  end

  assign raw_numerator_o          = num_q;
  assign raw_denominator_o        = den_q;
  assign reduced_numerator_o      = rnum_q;
  assign reduced_denominator_o    = rden_q;
  assign zero_denominator_error_o = err_q;

`ifndef NO_ASSERTIONS
  a_accept_goes_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_err_zeroes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && zero_denominator_error_o) |->
      (reduced_numerator_o == '0) && (reduced_denominator_o == '0))
    else $error("reduced fields not cleared on zero denominator");

  a_reduced_den_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !zero_denominator_error_o) |-> (reduced_denominator_o != '0))
    else $error("reduction produced a zero denominator");
`endif

endmodule

FILE: rtl/rgcd_divider.sv
module rgcd_divider
  import rgcd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  div_req_t            req_i,
  input  logic [NUM_BITS-1:0] dividend_i,
  input  logic [NUM_BITS-1:0] divisor_i,
  output div_rsp_t            rsp_o,
  output logic [NUM_BITS-1:0] quotient_o,
  output logic [NUM_BITS-1:0] remainder_o
);

  div_state_e            state_q, state_d;
  logic [NUM_BITS-1:0]   rem_q;
  logic [NUM_BITS-1:0]   dsh_q;
  logic [NUM_BITS-1:0]   quo_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic                  done_q;
  logic                  can_shift;
  logic                  can_sub;

  // divisor may double again without passing the partial remainder
  assign can_shift = ({dsh_q, 1'b0} <= {1'b0, rem_q});
  assign can_sub   = (rem_q >= dsh_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DIV_IDLE: begin
        if (req_i.start) state_d = DIV_ALIGN;
      end
      DIV_ALIGN: begin
        if (!can_shift) state_d = DIV_SUB;
      end
      DIV_SUB: begin
        if (cnt_q == '0) state_d = DIV_IDLE;
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == DIV_SUB) && (cnt_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      DIV_IDLE: begin
        if (req_i.start) begin
          rem_q <= dividend_i;
          dsh_q <= divisor_i;
          quo_q <= '0;
          cnt_q <= '0;
        end
      end
      DIV_ALIGN: begin
        if (can_shift) begin
          dsh_q <= {dsh_q[NUM_BITS-2:0], 1'b0};
          cnt_q <= cnt_q + CNT_BITS'(1);
        end
      end
      DIV_SUB: begin
        if (can_sub) rem_q <= rem_q - dsh_q;
        quo_q <= {quo_q[NUM_BITS-2:0], can_sub};
        if (cnt_q != '0) begin
          dsh_q <= {1'b0, dsh_q[NUM_BITS-1:1]};
          cnt_q <= cnt_q - CNT_BITS'(1);
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.done  = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule
